/* hdl/lrr_pkg.sv */
// Shared types, codes and constants for the live-range register reuse block.
`default_nettype none
package lrr_pkg;

    localparam int NUM_REGS_DEF = 64;

    localparam int FUNC_W = 2;
    localparam int REG_W  = 6;
    localparam int LINE_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_RECORD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

    typedef logic [3:0] t_dp_op;

    localparam t_dp_op OP_NONE     = 4'd0;
    localparam t_dp_op OP_ACCEPT   = 4'd1;
    localparam t_dp_op OP_CLR_STEP = 4'd2;
    localparam t_dp_op OP_REC_READ = 4'd3;
    localparam t_dp_op OP_REC_WRITE = 4'd4;
    localparam t_dp_op OP_LK_READ  = 4'd5;
    localparam t_dp_op OP_LK_LOAD  = 4'd6;
    localparam t_dp_op OP_C_START  = 4'd7;
    localparam t_dp_op OP_C_RDI    = 4'd8;
    localparam t_dp_op OP_C_CHKI   = 4'd9;
    localparam t_dp_op OP_C_RDJ    = 4'd10;
    localparam t_dp_op OP_C_HIT    = 4'd11;
    localparam t_dp_op OP_C_MISS   = 4'd12;
    localparam t_dp_op OP_C_FREE   = 4'd13;
    localparam t_dp_op OP_C_NEXT   = 4'd14;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic rd_valid;
        logic hit;
        logic in_range;
        logic last_i;
        logic last_j;
        logic out_busy;
    } t_dp_status;

endpackage
`default_nettype wire

/* hdl/lrr_if.sv */
// Valid/ready channel interfaces for use events and lookup results.
`default_nettype none
interface lrr_in_if;
    logic                          valid;
    logic                          ready;
    logic [lrr_pkg::FUNC_W-1:0]    func;
    logic [lrr_pkg::REG_W-1:0]     reg_req;
    logic [lrr_pkg::LINE_W-1:0]    line;

    modport source (output valid, output func, output reg_req, output line, input ready);
    modport sink   (input valid, input func, input reg_req, input line, output ready);
endinterface

interface lrr_out_if;
    logic                          valid;
    logic                          ready;
    logic [lrr_pkg::REG_W-1:0]     old_reg;
    logic [lrr_pkg::REG_W-1:0]     new_reg;

    modport source (output valid, output old_reg, output new_reg, input ready);
    modport sink   (input valid, input old_reg, input new_reg, output ready);
endinterface
`default_nettype wire

/* hdl/lrr_datapath.sv */
// Datapath: live-range and rename memories, scan counters and result register.
`default_nettype none
module lrr_datapath #(
    parameter int NUM_REGS = lrr_pkg::NUM_REGS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lrr_pkg::t_dp_cmd            i_cmd,
    output lrr_pkg::t_dp_status              o_status,
    input  wire logic [lrr_pkg::REG_W-1:0]   i_reg_req,
    input  wire logic [lrr_pkg::LINE_W-1:0]  i_line,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic [lrr_pkg::REG_W-1:0]        o_old_reg,
    output logic [lrr_pkg::REG_W-1:0]        o_new_reg
);
    localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [31:0] NR = 32'(NUM_REGS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_REGS - 1);

    logic                        mem_valid [NUM_REGS];
    logic [lrr_pkg::LINE_W-1:0]  mem_first [NUM_REGS];
    logic [lrr_pkg::LINE_W-1:0]  mem_last  [NUM_REGS];
    logic [lrr_pkg::REG_W-1:0]   mem_map   [NUM_REGS];

    logic [lrr_pkg::REG_W-1:0]   r_req;
    logic [lrr_pkg::LINE_W-1:0]  r_line;
    logic [IW-1:0]               r_i;
    logic [IW-1:0]               r_j;
    logic [lrr_pkg::LINE_W-1:0]  r_fi;
    logic [lrr_pkg::LINE_W-1:0]  r_li;
    logic                        r_rd_valid;
    logic [lrr_pkg::LINE_W-1:0]  r_rd_first;
    logic [lrr_pkg::LINE_W-1:0]  r_rd_last;
    logic [lrr_pkg::REG_W-1:0]   r_rd_map;
    logic                        r_out_valid;
    logic [lrr_pkg::REG_W-1:0]   r_old;
    logic [lrr_pkg::REG_W-1:0]   r_new;

    logic                        rd_en;
    logic [IW-1:0]               rd_addr;
    logic [IW-1:0]               req_idx;
    logic                        in_range;

    logic                        wv_en;
    logic [IW-1:0]               wv_addr;
    logic                        wv_d;
    logic                        wf_en;
    logic [IW-1:0]               wf_addr;
    logic [lrr_pkg::LINE_W-1:0]  wf_d;
    logic                        wl_en;
    logic [IW-1:0]               wl_addr;
    logic [lrr_pkg::LINE_W-1:0]  wl_d;
    logic                        wm_en;
    logic [IW-1:0]               wm_addr;
    logic [lrr_pkg::REG_W-1:0]   wm_d;

    assign req_idx  = IW'(r_req);
    assign in_range = 32'(r_req) < NR;

    assign o_status.rd_valid = r_rd_valid;
    assign o_status.hit      = !r_rd_valid || (r_rd_last < r_fi);
    assign o_status.in_range = in_range;
    assign o_status.last_i   = (r_i == LAST_IDX);
    assign o_status.last_j   = (IW'(r_j + 1'b1) == r_i);
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_old_reg   = r_old;
    assign o_new_reg   = r_new;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_i;
        wv_en = 1'b0; wv_addr = r_i; wv_d = 1'b0;
        wf_en = 1'b0; wf_addr = r_i; wf_d = '0;
        wl_en = 1'b0; wl_addr = r_i; wl_d = '0;
        wm_en = 1'b0; wm_addr = r_i; wm_d = '0;
        unique case (i_cmd.op)
            lrr_pkg::OP_CLR_STEP: begin
                wv_en = 1'b1;
                wf_en = 1'b1;
                wl_en = 1'b1;
                wm_en = 1'b1;
                wm_d  = lrr_pkg::REG_W'(r_i);
            end
            lrr_pkg::OP_REC_READ, lrr_pkg::OP_LK_READ: begin
                rd_en   = 1'b1;
                rd_addr = req_idx;
            end
            lrr_pkg::OP_REC_WRITE: begin
                wl_en   = 1'b1;
                wl_addr = req_idx;
                wl_d    = r_line;
                wv_en   = !r_rd_valid;
                wv_addr = req_idx;
                wv_d    = 1'b1;
                wf_en   = !r_rd_valid;
                wf_addr = req_idx;
                wf_d    = r_line;
            end
            lrr_pkg::OP_C_START: begin
                wm_en   = 1'b1;
                wm_addr = '0;
                wm_d    = '0;
            end
            lrr_pkg::OP_C_RDI: begin
                rd_en = 1'b1;
            end
            lrr_pkg::OP_C_CHKI: begin
                wm_en = 1'b1;
                wm_d  = lrr_pkg::REG_W'(r_i);
            end
            lrr_pkg::OP_C_RDJ: begin
                rd_en   = 1'b1;
                rd_addr = r_j;
            end
            lrr_pkg::OP_C_HIT: begin
                wv_en   = 1'b1;
                wv_addr = r_j;
                wv_d    = 1'b1;
                wf_en   = 1'b1;
                wf_addr = r_j;
                wf_d    = r_fi;
                wl_en   = 1'b1;
                wl_addr = r_j;
                wl_d    = r_li;
                wm_en   = 1'b1;
                wm_d    = lrr_pkg::REG_W'(r_j);
            end
            lrr_pkg::OP_C_FREE: begin
                wv_en = 1'b1;
                wv_d  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wv_en) mem_valid[wv_addr] <= wv_d;
        if (wf_en) mem_first[wf_addr] <= wf_d;
        if (wl_en) mem_last[wl_addr]  <= wl_d;
        if (wm_en) mem_map[wm_addr]   <= wm_d;
        if (rd_en) begin
            r_rd_valid <= mem_valid[rd_addr];
            r_rd_first <= mem_first[rd_addr];
            r_rd_last  <= mem_last[rd_addr];
            r_rd_map   <= mem_map[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            lrr_pkg::OP_ACCEPT: begin
                r_req  <= i_reg_req;
                r_line <= i_line;
            end
            lrr_pkg::OP_C_CHKI: begin
                r_fi <= r_rd_first;
                r_li <= r_rd_last;
            end
            lrr_pkg::OP_LK_LOAD: begin
                r_old <= r_req;
                r_new <= in_range ? r_rd_map : r_req;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                lrr_pkg::OP_ACCEPT:   r_i <= '0;
                lrr_pkg::OP_CLR_STEP: r_i <= IW'(r_i + 1'b1);
                lrr_pkg::OP_C_START:  r_i <= IW'(1);
                lrr_pkg::OP_C_NEXT:   r_i <= IW'(r_i + 1'b1);
                lrr_pkg::OP_C_CHKI:   r_j <= '0;
                lrr_pkg::OP_C_MISS:   r_j <= IW'(r_j + 1'b1);
                default: begin
                end
            endcase
            if (i_cmd.op == lrr_pkg::OP_LK_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/lrr_ctrl.sv */
// Controller: sequences record, lookup, clear and the rename scan.
`default_nettype none
module lrr_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [lrr_pkg::FUNC_W-1:0]  i_in_func,
    input  wire lrr_pkg::t_dp_status         i_status,
    output logic                             o_in_ready,
    output lrr_pkg::t_dp_cmd                 o_cmd
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLR     = 4'd1;
    localparam logic [3:0] S_REC_RD  = 4'd2;
    localparam logic [3:0] S_REC_WR  = 4'd3;
    localparam logic [3:0] S_LK_RD   = 4'd4;
    localparam logic [3:0] S_LK_OUT  = 4'd5;
    localparam logic [3:0] S_C_START = 4'd6;
    localparam logic [3:0] S_C_RDI   = 4'd7;
    localparam logic [3:0] S_C_CHKI  = 4'd8;
    localparam logic [3:0] S_C_RDJ   = 4'd9;
    localparam logic [3:0] S_C_CHKJ  = 4'd10;
    localparam logic [3:0] S_C_FREE  = 4'd11;
    localparam logic [3:0] S_C_NEXT  = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = lrr_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = lrr_pkg::OP_ACCEPT;
                    unique case (i_in_func)
                        lrr_pkg::FUNC_RECORD:  n_state = S_REC_RD;
                        lrr_pkg::FUNC_COMPUTE: n_state = S_C_START;
                        lrr_pkg::FUNC_LOOKUP:  n_state = S_LK_RD;
                        lrr_pkg::FUNC_CLEAR:   n_state = S_CLR;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.op = lrr_pkg::OP_CLR_STEP;
                if (i_status.last_i) n_state = S_IDLE;
            end
            S_REC_RD: begin
                if (i_status.in_range) begin
                    o_cmd.op = lrr_pkg::OP_REC_READ;
                    n_state  = S_REC_WR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_REC_WR: begin
                o_cmd.op = lrr_pkg::OP_REC_WRITE;
                n_state  = S_IDLE;
            end
            S_LK_RD: begin
                o_cmd.op = lrr_pkg::OP_LK_READ;
                n_state  = S_LK_OUT;
            end
            S_LK_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = lrr_pkg::OP_LK_LOAD;
                    n_state  = S_IDLE;
                end
            end
            S_C_START: begin
                o_cmd.op = lrr_pkg::OP_C_START;
                n_state  = S_C_RDI;
            end
            S_C_RDI: begin
                o_cmd.op = lrr_pkg::OP_C_RDI;
                n_state  = S_C_CHKI;
            end
            S_C_CHKI: begin
                o_cmd.op = lrr_pkg::OP_C_CHKI;
                n_state  = i_status.rd_valid ? S_C_RDJ : S_C_NEXT;
            end
            S_C_RDJ: begin
                o_cmd.op = lrr_pkg::OP_C_RDJ;
                n_state  = S_C_CHKJ;
            end
            S_C_CHKJ: begin
                if (i_status.hit) begin
                    o_cmd.op = lrr_pkg::OP_C_HIT;
                    n_state  = S_C_FREE;
                end else begin
                    o_cmd.op = lrr_pkg::OP_C_MISS;
                    n_state  = i_status.last_j ? S_C_NEXT : S_C_RDJ;
                end
            end
            S_C_FREE: begin
                o_cmd.op = lrr_pkg::OP_C_FREE;
                n_state  = S_C_NEXT;
            end
            S_C_NEXT: begin
                o_cmd.op = lrr_pkg::OP_C_NEXT;
                n_state  = i_status.last_i ? S_IDLE : S_C_RDI;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* hdl/live_range_register_reuse_core.sv */
// Top level of the live-range register reuse block.
// Register-use events (func record) store the first and last line of use per
// register; a compute command renames each used register onto the lowest lower
// register that is free or whose range has ended, and a lookup returns a
// register's new number as one transfer on the output channel. Only one item is
// in work at a time; a lookup may wait for the output register, and a clear
// sweeps all NUM_REGS entries. A compute walks every register i from 1 up and,
// for a used one, tests lower registers one at a time over the single memory
// read port. After reset the tables are swept, during which no item is accepted.
`default_nettype none
module live_range_register_reuse_core #(
    parameter int NUM_REGS = lrr_pkg::NUM_REGS_DEF
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    lrr_in_if.sink    i_in,
    lrr_out_if.source o_out
);
    lrr_pkg::t_dp_cmd    cmd;
    lrr_pkg::t_dp_status status;

    lrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.func),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    lrr_datapath #(
        .NUM_REGS (NUM_REGS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_reg_req   (i_in.reg_req),
        .i_line      (i_in.line),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_old_reg   (o_out.old_reg),
        .o_new_reg   (o_out.new_reg)
    );

endmodule
`default_nettype wire

/* hdl/lrr_checker.sv */
// Port-level checks of the live-range register reuse block and their binding.
`default_nettype none
module lrr_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [lrr_pkg::REG_W-1:0]   i_old_reg,
    input wire logic [lrr_pkg::REG_W-1:0]   i_new_reg
);
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("block not busy and empty after reset");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while an item is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_old_reg) && $stable(i_new_reg))
        else $error("stalled result changed");

endmodule

bind live_range_register_reuse_core lrr_checker u_lrr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_old_reg   (o_out.old_reg),
    .i_new_reg   (o_out.new_reg)
);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench for live_range_register_reuse_core: table and random transfers vs a predictor.
module tb;

    localparam int NREG = lrr_pkg::NUM_REGS_DEF;

    typedef struct {
        logic [lrr_pkg::FUNC_W-1:0] func;
        logic [lrr_pkg::REG_W-1:0]  reg_req;
        logic [lrr_pkg::LINE_W-1:0] line;
        bit                         typed;
        logic [lrr_pkg::REG_W-1:0]  typed_new;
    } t_stim;

    typedef struct {
        logic [lrr_pkg::REG_W-1:0] old_reg;
        logic [lrr_pkg::REG_W-1:0] new_reg;
    } t_rename;

    logic i_clk;
    logic i_rst_n;

    lrr_in_if  in_ch ();
    lrr_out_if out_ch ();

    live_range_register_reuse_core #(.NUM_REGS(NREG)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state
    bit                         live_valid [NREG];
    logic [lrr_pkg::LINE_W-1:0] live_first [NREG];
    logic [lrr_pkg::LINE_W-1:0] live_last  [NREG];
    logic [lrr_pkg::REG_W-1:0]  rename_tab [NREG];

    t_stim   stim_q [$];
    t_rename rename_q [$];

    int     accept_idx   = 0;
    int     errors       = 0;
    int     snd_idle     = 0;
    int     rcv_idle     = 0;
    int     results_seen = 0;
    int     hold_left    = 0;
    bit     hold_done    = 1'b0;
    longint cycles       = 0;
    longint cycle_limit  = 64'd4000000;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [lrr_pkg::REG_W-1:0] to_reg(int v);
        logic [31:0] w;
        w = v;
        return w[lrr_pkg::REG_W-1:0];
    endfunction

    function automatic logic [lrr_pkg::LINE_W-1:0] to_line(int v);
        logic [31:0] w;
        w = v;
        return w[lrr_pkg::LINE_W-1:0];
    endfunction

    function automatic void wipe_tables();
        for (int r = 0; r < NREG; r++) begin
            live_valid[r] = 1'b0;
            live_first[r] = '0;
            live_last[r]  = '0;
            rename_tab[r] = to_reg(r);
        end
    endfunction

    function automatic void rename_pass();
        rename_tab[0] = '0;
        for (int i = 1; i < NREG; i++) begin
            rename_tab[i] = to_reg(i);
            if (live_valid[i]) begin
                for (int j = 0; j < i; j++) begin
                    if (!live_valid[j] || live_last[j] < live_first[i]) begin
                        rename_tab[i] = to_reg(j);
                        live_valid[j] = 1'b1;
                        live_first[j] = live_first[i];
                        live_last[j]  = live_last[i];
                        live_valid[i] = 1'b0;
                        break;
                    end
                end
            end
        end
    endfunction

    function automatic void predict(t_stim s);
        t_rename e;
        case (s.func)
            lrr_pkg::FUNC_RECORD: begin
                live_last[s.reg_req] = s.line;
                if (!live_valid[s.reg_req]) begin
                    live_valid[s.reg_req] = 1'b1;
                    live_first[s.reg_req] = s.line;
                end
            end
            lrr_pkg::FUNC_COMPUTE: rename_pass();
            lrr_pkg::FUNC_LOOKUP: begin
                e.old_reg = s.reg_req;
                e.new_reg = s.typed ? s.typed_new : rename_tab[s.reg_req];
                rename_q.push_back(e);
            end
            default: wipe_tables();
        endcase
    endfunction

    function automatic void add_item(logic [lrr_pkg::FUNC_W-1:0] f,
                                     logic [lrr_pkg::REG_W-1:0] r,
                                     logic [lrr_pkg::LINE_W-1:0] l, bit t,
                                     logic [lrr_pkg::REG_W-1:0] tn);
        t_stim s;
        s.func      = f;
        s.reg_req   = r;
        s.line      = l;
        s.typed     = t;
        s.typed_new = tn;
        stim_q.push_back(s);
    endfunction

    function automatic void build_table();
        add_item(lrr_pkg::FUNC_LOOKUP,  6'd0,  16'd0,    1'b1, 6'd0);
        add_item(lrr_pkg::FUNC_LOOKUP,  6'd63, 16'd0,    1'b1, 6'd63);
        add_item(lrr_pkg::FUNC_RECORD,  6'd1,  16'd0,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_RECORD,  6'd2,  16'd3,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_RECORD,  6'd1,  16'd5,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_RECORD,  6'd3,  16'd8,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_RECORD,  6'd63, 16'hFFFF, 1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_RECORD,  6'd3,  16'd2,    1'b0, 6'd0);  // line goes backward
        add_item(lrr_pkg::FUNC_RECORD,  6'd5,  16'hFFFF, 1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_COMPUTE, 6'd0,  16'd0,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_LOOKUP,  6'd0,  16'd0,    1'b1, 6'd0);
        add_item(lrr_pkg::FUNC_LOOKUP,  6'd1,  16'd0,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_LOOKUP,  6'd2,  16'd0,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_LOOKUP,  6'd3,  16'd0,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_LOOKUP,  6'd63, 16'd0,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_COMPUTE, 6'd63, 16'hFFFF, 1'b0, 6'd0);  // second pass on moved state
        add_item(lrr_pkg::FUNC_LOOKUP,  6'd63, 16'd0,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_CLEAR,   6'd0,  16'd0,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_LOOKUP,  6'd1,  16'd0,    1'b1, 6'd1);
        add_item(lrr_pkg::FUNC_LOOKUP,  6'd63, 16'd0,    1'b1, 6'd63);
        add_item(lrr_pkg::FUNC_RECORD,  6'd0,  16'd10,   1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_RECORD,  6'd42, 16'd20,   1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_RECORD,  6'd21, 16'd30,   1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_COMPUTE, 6'd0,  16'd0,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_LOOKUP,  6'd42, 16'd0,    1'b0, 6'd0);
        add_item(lrr_pkg::FUNC_LOOKUP,  6'd21, 16'd0,    1'b0, 6'd0);
    endfunction

    function automatic void build_random(int target);
        logic [lrr_pkg::REG_W-1:0] pool [NREG];
        int npool;
        int nrec;
        int nlk;
        int base;
        int f;
        while (stim_q.size() < target) begin
            if ($urandom_range(99) < 85) begin
                // well-formed sequence: optional clear, uses in line order, compute, lookups
                if ($urandom_range(99) < 70)
                    add_item(lrr_pkg::FUNC_CLEAR, to_reg($urandom), to_line($urandom),
                             1'b0, 6'd0);
                npool = ($urandom_range(9) == 0) ? $urandom_range(NREG, 32)
                                                 : $urandom_range(12, 1);
                for (int k = 0; k < npool; k++)
                    pool[k] = to_reg($urandom_range(NREG - 1, 0));
                base = ($urandom_range(3) == 0) ? $urandom_range(50, 0)
                                                : $urandom_range(65535, 0);
                nrec = $urandom_range(npool * 2, 1);
                for (int k = 0; k < nrec; k++) begin
                    base = base + $urandom_range(300, 0);
                    if (base > 65535)
                        base = 65535;
                    add_item(lrr_pkg::FUNC_RECORD, pool[$urandom_range(npool - 1, 0)],
                             to_line(base), 1'b0, 6'd0);
                end
                if ($urandom_range(99) < 15)
                    add_item(lrr_pkg::FUNC_LOOKUP, to_reg($urandom), to_line($urandom),
                             1'b0, 6'd0);
                add_item(lrr_pkg::FUNC_COMPUTE, to_reg($urandom), to_line($urandom),
                         1'b0, 6'd0);
                if ($urandom_range(99) < 15)
                    add_item(lrr_pkg::FUNC_COMPUTE, to_reg($urandom), to_line($urandom),
                             1'b0, 6'd0);
                nlk = $urandom_range(8, 1);
                for (int k = 0; k < nlk; k++) begin
                    if ($urandom_range(1) == 0)
                        add_item(lrr_pkg::FUNC_LOOKUP, pool[$urandom_range(npool - 1, 0)],
                                 to_line($urandom), 1'b0, 6'd0);
                    else
                        add_item(lrr_pkg::FUNC_LOOKUP, to_reg($urandom), to_line($urandom),
                                 1'b0, 6'd0);
                end
            end else begin
                for (int k = 0; k < 8; k++) begin
                    f = $urandom_range(99);
                    if (f < 45)
                        add_item(lrr_pkg::FUNC_RECORD, to_reg($urandom), to_line($urandom),
                                 1'b0, 6'd0);
                    else if (f < 55)
                        add_item(lrr_pkg::FUNC_COMPUTE, to_reg($urandom), to_line($urandom),
                                 1'b0, 6'd0);
                    else if (f < 90)
                        add_item(lrr_pkg::FUNC_LOOKUP, to_reg($urandom), to_line($urandom),
                                 1'b0, 6'd0);
                    else
                        add_item(lrr_pkg::FUNC_CLEAR, to_reg($urandom), to_line($urandom),
                                 1'b0, 6'd0);
                end
            end
        end
        add_item(lrr_pkg::FUNC_LOOKUP, to_reg($urandom), to_line($urandom), 1'b0, 6'd0);
    endfunction

    // result check, then prediction of the input transfer at the same edge
    always @(posedge i_clk) begin
        t_rename e;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (rename_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: old_reg=%0d new_reg=%0d",
                                 out_ch.old_reg, out_ch.new_reg);
                end else begin
                    e = rename_q.pop_front();
                    if (out_ch.old_reg !== e.old_reg || out_ch.new_reg !== e.new_reg) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected old_reg=%0d new_reg=%0d,",
                                      " got old_reg=%0d new_reg=%0d"},
                                     e.old_reg, e.new_reg, out_ch.old_reg, out_ch.new_reg);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                predict(stim_q[accept_idx]);
                accept_idx++;
            end
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!hold_done && results_seen == 40) begin
            hold_done    <= 1'b1;
            hold_left    <= 600;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rcv_idle);
        end
        if (out_ch.valid && out_ch.ready)
            results_seen <= results_seen + 1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == cycle_limit) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        int n_dir;
        int n_rnd;
        int n_comp;
        int phase;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.func    <= lrr_pkg::FUNC_RECORD;
        in_ch.reg_req <= '0;
        in_ch.line    <= '0;
        wipe_tables();
        build_table();
        n_dir = stim_q.size();
        build_random(1700);
        n_rnd = stim_q.size() - n_dir;
        n_comp = 0;
        foreach (stim_q[k])
            if (stim_q[k].func == lrr_pkg::FUNC_COMPUTE)
                n_comp++;
        // worst case per transfer with stalls, per compute pass, startup sweep and hold-off
        cycle_limit = 4 * (longint'(stim_q.size()) * 300
                      + longint'(n_comp) * NREG * (NREG + 8) + 2000) + 20000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < stim_q.size(); i++) begin
            if (i >= n_dir) begin
                phase = (i - n_dir) * 4 / n_rnd;
                case (phase)
                    0: begin
                        snd_idle = 0;
                        rcv_idle = 0;
                    end
                    1: begin
                        snd_idle = 46;
                        rcv_idle = 0;
                    end
                    2: begin
                        snd_idle = 0;
                        rcv_idle = 46;
                    end
                    default: begin
                        snd_idle = 8;
                        rcv_idle = 8;
                    end
                endcase
            end
            if (i == n_dir + n_rnd / 2) begin
                // drain everything before going on
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (accept_idx != i || rename_q.size() != 0)
                    @(posedge i_clk);
            end
            while ($urandom_range(99) < snd_idle) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            in_ch.valid   <= 1'b1;
            in_ch.func    <= stim_q[i].func;
            in_ch.reg_req <= stim_q[i].reg_req;
            in_ch.line    <= stim_q[i].line;
            @(posedge i_clk);
            while (!in_ch.ready)
                @(posedge i_clk);
        end
        in_ch.valid <= 1'b0;
        while (accept_idx < stim_q.size() || rename_q.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && rename_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

/* files.f */
hdl/lrr_pkg.sv
hdl/lrr_if.sv
hdl/lrr_datapath.sv
hdl/lrr_ctrl.sv
hdl/live_range_register_reuse_core.sv
hdl/lrr_checker.sv
tb/tb.sv
